>>> sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and codes for the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned HALF_W    = 16;
  localparam int unsigned IN_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd80;

  localparam logic [2:0] FUNC_NONE  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  typedef struct packed {
    logic       cmd;
    logic [2:0] func;
    logic [7:0] byte_in;
    logic       ack_to_send;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic valid;
    item_t item;
  } qhead_t;

endpackage

>>> sv/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// accepts input words, decodes the command and queues them for the engine
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [i2cm_pkg::IN_DATA_W-1:0]      in_tdata,
  output i2cm_pkg::qhead_t                    head,
  input  logic                                pop
);

  i2cm_pkg::item_t                    q_mem [i2cm_pkg::QDEPTH];
  logic [i2cm_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [i2cm_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [i2cm_pkg::QCNT_W-1:0]        count_r, count_nxt;
  i2cm_pkg::item_t                    dec;
  logic                               push;
  logic                               do_pop;

  // decode
  always_comb begin
    dec.func        = in_tdata[2:0];
    dec.byte_in     = in_tdata[10:3];
    dec.ack_to_send = in_tdata[11];
    dec.sda_level   = in_tdata[12];
    dec.cmd         = (in_tdata[2:0] == i2cm_pkg::FUNC_START) ||
                      (in_tdata[2:0] == i2cm_pkg::FUNC_STOP)  ||
                      (in_tdata[2:0] == i2cm_pkg::FUNC_WRITE) ||
                      (in_tdata[2:0] == i2cm_pkg::FUNC_READ);
  end

  assign in_tready = (count_r != i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.item  = q_mem[rd_ptr_r];

endmodule

>>> sv/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// bus phase sequencer, one queued word per tick, with output register
// ----------------------------------------------------------------------------
module i2cm_engine #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [i2cm_pkg::HALF_W-1:0]         half_period,
  input  i2cm_pkg::qhead_t                    head,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_ST1   = 5'd1;
  localparam logic [4:0] PH_ST2   = 5'd2;
  localparam logic [4:0] PH_SP1   = 5'd3;
  localparam logic [4:0] PH_SP2   = 5'd4;
  localparam logic [4:0] PH_SP3   = 5'd5;
  localparam logic [4:0] PH_WB_LO = 5'd6;
  localparam logic [4:0] PH_WB_HI = 5'd7;
  localparam logic [4:0] PH_WA_LO = 5'd8;
  localparam logic [4:0] PH_WA_HI = 5'd9;
  localparam logic [4:0] PH_RB_HI = 5'd10;
  localparam logic [4:0] PH_RB_LO = 5'd11;
  localparam logic [4:0] PH_RA_LO = 5'd12;
  localparam logic [4:0] PH_RA_HI = 5'd13;

  localparam logic [32:0] CMAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic [4:0]             phase_r, phase_nxt;
  logic [3:0]             bit_r, bit_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [COUNT_WIDTH-1:0] wait_r, wait_nxt, wait_dec, load;
  logic                   ackl_r, ackl_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic [7:0]             rx_r, rx_nxt;
  logic                   lack_r, lack_nxt;
  logic                   done, rej;
  logic                   take;
  logic                   ov_r;
  logic [13:0]            od_r;
  logic [32:0]            hp_ext;
  logic [7:0]             sh1;
  logic [3:0]             bi1;
  i2cm_pkg::item_t        it;

  assign it   = head.item;
  assign take = head.valid && (!ov_r || out_tready);
  assign pop  = take;

  // wait load: zero counts as one, saturate at counter range
  always_comb begin
    hp_ext = {17'd0, half_period};
    if (half_period == '0) begin
      load = COUNT_WIDTH'(1);
    end else if (hp_ext > CMAX) begin
      load = CMAX[COUNT_WIDTH-1:0];
    end else begin
      load = hp_ext[COUNT_WIDTH-1:0];
    end
  end

  assign wait_dec = (wait_r != '0) ? wait_r - 1'b1 : wait_r;
  assign sh1      = {shift_r[6:0], 1'b0};
  assign bi1      = bit_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    ackl_nxt  = ackl_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    rx_nxt    = rx_r;
    lack_nxt  = lack_r;
    done      = 1'b0;
    rej       = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (it.cmd) begin
        bit_nxt  = '0;
        wait_nxt = load;
        case (it.func)
          i2cm_pkg::FUNC_START: begin
            sda_nxt   = 1'b0;
            scl_nxt   = 1'b0;
            phase_nxt = PH_ST1;
          end
          i2cm_pkg::FUNC_STOP: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_SP1;
          end
          i2cm_pkg::FUNC_WRITE: begin
            shift_nxt = it.byte_in;
            sda_nxt   = !it.byte_in[7];
            phase_nxt = PH_WB_LO;
          end
          default: begin
            ackl_nxt  = it.ack_to_send;
            shift_nxt = '0;
            sda_nxt   = 1'b0;
            scl_nxt   = 1'b0;
            phase_nxt = PH_RB_HI;
          end
        endcase
      end
    end else begin
      rej      = it.cmd;
      wait_nxt = wait_dec;
      if (wait_dec == '0) begin
        case (phase_r)
          PH_ST1: begin
            sda_nxt = 1'b1; wait_nxt = load; phase_nxt = PH_ST2;
          end
          PH_ST2: begin
            scl_nxt = 1'b1; done = 1'b1;
          end
          PH_SP1: begin
            scl_nxt = 1'b0; wait_nxt = load; phase_nxt = PH_SP2;
          end
          PH_SP2: begin
            sda_nxt = 1'b0; wait_nxt = load; phase_nxt = PH_SP3;
          end
          PH_SP3: begin
            done = 1'b1;
          end
          PH_WB_LO: begin
            scl_nxt = 1'b0; wait_nxt = load; phase_nxt = PH_WB_HI;
          end
          PH_WB_HI: begin
            scl_nxt   = 1'b1;
            bit_nxt   = bi1;
            shift_nxt = sh1;
            wait_nxt  = load;
            if (bi1 < 4'd8) begin
              sda_nxt   = !sh1[7];
              phase_nxt = PH_WB_LO;
            end else begin
              sda_nxt   = 1'b0;
              phase_nxt = PH_WA_LO;
            end
          end
          PH_WA_LO: begin
            scl_nxt = 1'b0; wait_nxt = load; phase_nxt = PH_WA_HI;
          end
          PH_WA_HI: begin
            lack_nxt = !it.sda_level;
            scl_nxt  = 1'b1;
            done     = 1'b1;
          end
          PH_RB_HI: begin
            shift_nxt = {shift_r[6:0], it.sda_level};
            scl_nxt   = 1'b1;
            wait_nxt  = load;
            phase_nxt = PH_RB_LO;
          end
          PH_RB_LO: begin
            bit_nxt  = bi1;
            wait_nxt = load;
            if (bi1 < 4'd8) begin
              scl_nxt   = 1'b0;
              phase_nxt = PH_RB_HI;
            end else begin
              sda_nxt   = ackl_r;
              phase_nxt = PH_RA_LO;
            end
          end
          PH_RA_LO: begin
            scl_nxt = 1'b0; wait_nxt = load; phase_nxt = PH_RA_HI;
          end
          PH_RA_HI: begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b0;
            rx_nxt  = shift_r;
            done    = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      shift_r <= '0;
      wait_r  <= '0;
      ackl_r  <= 1'b0;
      scl_r   <= 1'b0;
      sda_r   <= 1'b0;
      rx_r    <= '0;
      lack_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        wait_r  <= wait_nxt;
        ackl_r  <= ackl_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        rx_r    <= rx_nxt;
        lack_r  <= lack_nxt;
        ov_r    <= 1'b1;
      end else if (out_tready) begin
        ov_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      od_r <= {rej, lack_nxt, rx_nxt, done, (phase_nxt != PH_IDLE), sda_nxt, scl_nxt};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, od_r};

endmodule

>>> sv/i2c_master_bit_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// open-drain i2c master: start, stop, write byte and read byte sequencing
// ----------------------------------------------------------------------------
// usage: every word on the in_ channel is one bus tick carrying the sampled
// sda level and, when the engine is idle, an optional command. every word
// produces exactly one word on the out_ channel with the pin drives and
// status for that tick. words are decoded and queued in a four-word queue,
// then consumed by the phase sequencer one per cycle, while the output is
// not stalled, into an output register. an accepted word passes through the
// queue and then the output register before out_tvalid rises. the sequencer
// takes one step per word. if the receiver stalls, the output register holds
// its word, the queue fills and in_tready drops after four more words.
// cfg_ writes half_period and are always ready; the user must write them only
// while the engine is idle, as the block itself does not enforce it. after
// reset both lines are released, half_period is 80, the queue is empty and no
// output word is pending.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[2:0], byte_in[10:3], ack_to_send[11], sda_level[12], zeros[15:13]
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_pull_low[0], sda_pull_low[1], busy_res[2], done_res[3], byte_out[11:4],
  // ack_seen[12], rejected[13], zeros[15:14]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [i2cm_pkg::HALF_W-1:0] half_r;
  i2cm_pkg::qhead_t            head;
  logic                        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= i2cm_pkg::HALF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      half_r <= cfg_data;
    end
  end

  i2cm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .head      (head),
    .pop       (pop)
  );

  i2cm_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .half_period (half_r),
    .head        (head),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
